@@ src/direct_mapped_cache_controller_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the cache controller.
// Each one checks a property at every rising clk edge and is held off while
// rst_n is low.
// ---------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_CACHE_CONTROLLER_MACROS_SVH
`define DIRECT_MAPPED_CACHE_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DMC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/dmc_pkg.sv @@
// ---------------------------------------------------------------------------
// dmc_pkg
// Sizes, state codes, stream layouts and the command and status bundles
// shared by the cache controller modules.
// ---------------------------------------------------------------------------
package dmc_pkg;

    localparam int LINE_COUNT   = 16;
    localparam int ADDRESS_BITS = 32;
    localparam int DATA_BITS    = 32;
    localparam int IDX_BITS     = $clog2(LINE_COUNT);
    localparam int TAG_BITS     = ADDRESS_BITS - IDX_BITS;

    // Fixed widths of the fields on the stream ports.
    localparam int FIELD_W = 32;
    localparam int STATE_W = 2;

    localparam int S_FIELDS_W = 3 + 3 * FIELD_W;
    localparam int M_FIELDS_W = 6 + 3 * FIELD_W + STATE_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Controller state code as it appears on the result stream.
    localparam logic [STATE_W-1:0] CODE_IDLE       = 2'd0;
    localparam logic [STATE_W-1:0] CODE_COMPARE    = 2'd1;
    localparam logic [STATE_W-1:0] CODE_WRITE_BACK = 2'd2;
    localparam logic [STATE_W-1:0] CODE_ALLOCATE   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE       = 4'b0001,
        ST_COMPARE    = 4'b0010,
        ST_WRITE_BACK = 4'b0100,
        ST_ALLOCATE   = 4'b1000
    } state_t;

    typedef struct packed {
        logic                request_valid;
        logic                request_is_write;
        logic [FIELD_W-1:0]  request_address;
        logic [FIELD_W-1:0]  request_write_data;
        logic                memory_ready;
        logic [FIELD_W-1:0]  memory_read_data;
    } in_item_t;

    typedef struct packed {
        logic                cpu_ready;
        logic [FIELD_W-1:0]  cpu_read_data;
        logic                cpu_stall;
        logic                memory_read_strobe;
        logic                memory_write_strobe;
        logic [FIELD_W-1:0]  memory_address;
        logic [FIELD_W-1:0]  memory_write_data;
        logic                line_valid_seen;
        logic                line_dirty_seen;
        logic [STATE_W-1:0]  controller_state;
    } out_item_t;

    // Controller to datapath. The update commands only fire on an accepted beat.
    typedef struct packed {
        logic [STATE_W-1:0] state_code;
        logic               latch_req;
        logic               commit_write;
        logic               serve_read;
        logic               clear_dirty;
        logic               fill_line;
        logic               show_line;
        logic               ready;
        logic               stall;
        logic               rd_strobe;
        logic               wr_strobe;
    } dmc_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic req_valid;
        logic held_is_write;
        logic mem_ready;
        logic hit;
        logic victim_dirty;
    } dmc_status_t;

endpackage

@@ src/dmc_ctrl.sv @@
// ---------------------------------------------------------------------------
// dmc_ctrl
// Four-state controller: idle, compare tag, write back and allocate. It
// advances by one state step per accepted beat.
// ---------------------------------------------------------------------------
`include "direct_mapped_cache_controller_macros.svh"

module dmc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  dmc_pkg::dmc_status_t sts,
    output dmc_pkg::dmc_cmd_t    cmd
);
    import dmc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.state_code = CODE_IDLE;
                if (sts.req_valid)
                begin
                    cmd.latch_req = step;
                    cmd.stall     = 1'b1;
                    state_next    = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                cmd.state_code = CODE_COMPARE;
                cmd.show_line  = 1'b1;
                if (sts.hit)
                begin
                    cmd.ready        = 1'b1;
                    cmd.commit_write = step && sts.held_is_write;
                    cmd.serve_read   = !sts.held_is_write;
                    state_next       = ST_IDLE;
                end
                else
                begin
                    cmd.stall  = 1'b1;
                    state_next = sts.victim_dirty ? ST_WRITE_BACK : ST_ALLOCATE;
                end
            end
            ST_WRITE_BACK:
            begin
                cmd.state_code = CODE_WRITE_BACK;
                cmd.wr_strobe  = 1'b1;
                cmd.stall      = 1'b1;
                if (sts.mem_ready)
                begin
                    cmd.clear_dirty = step;
                    state_next      = ST_ALLOCATE;
                end
            end
            ST_ALLOCATE:
            begin
                cmd.state_code = CODE_ALLOCATE;
                cmd.rd_strobe  = 1'b1;
                cmd.stall      = 1'b1;
                if (sts.mem_ready)
                begin
                    cmd.fill_line = step;
                    state_next    = ST_COMPARE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end

    `DMC_ASSERT_NEXT(a_hold_without_beat, !step, $stable(state_reg),
                     "state moved without a beat")
    `DMC_ASSERT_NEXT(a_fill_to_compare, cmd.fill_line, state_reg == ST_COMPARE,
                     "fill did not return to compare")
    `DMC_ASSERT_NEXT(a_hit_to_idle, step && cmd.ready, state_reg == ST_IDLE,
                     "hit did not return to idle")

endmodule

@@ src/dmc_datapath.sv @@
// ---------------------------------------------------------------------------
// dmc_datapath
// Request holding registers, the line store (valid, dirty, tag and data) and
// the result fields for the current beat.
// ---------------------------------------------------------------------------
`include "direct_mapped_cache_controller_macros.svh"

module dmc_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dmc_pkg::in_item_t    in_item,
    input  dmc_pkg::dmc_cmd_t    cmd,
    output dmc_pkg::dmc_status_t sts,
    output dmc_pkg::out_item_t   result
);
    import dmc_pkg::*;

    logic [ADDRESS_BITS-1:0] held_addr_reg;
    logic [DATA_BITS-1:0]    held_wdata_reg;
    logic                    held_is_write_reg;

    logic [LINE_COUNT-1:0]   line_valid_reg;
    logic [LINE_COUNT-1:0]   line_dirty_reg;
    logic [TAG_BITS-1:0]     line_tag_reg  [LINE_COUNT];
    logic [DATA_BITS-1:0]    line_data_reg [LINE_COUNT];

    logic [IDX_BITS-1:0]     idx;
    logic [TAG_BITS-1:0]     held_tag;
    logic                    sel_valid;
    logic                    sel_dirty;
    logic [TAG_BITS-1:0]     sel_tag;
    logic [DATA_BITS-1:0]    sel_data;
    logic                    hit;
    logic [ADDRESS_BITS-1:0] victim_addr;

    assign idx         = held_addr_reg[IDX_BITS-1:0];
    assign held_tag    = held_addr_reg[ADDRESS_BITS-1:IDX_BITS];
    assign sel_valid   = line_valid_reg[idx];
    assign sel_dirty   = line_dirty_reg[idx];
    assign sel_tag     = line_tag_reg[idx];
    assign sel_data    = line_data_reg[idx];
    assign hit         = sel_valid && (sel_tag == held_tag);
    // The old block goes back to its own address, built from its stored tag.
    assign victim_addr = {sel_tag, idx};

    always_comb
    begin
        sts.req_valid     = in_item.request_valid;
        sts.held_is_write = held_is_write_reg;
        sts.mem_ready     = in_item.memory_ready;
        sts.hit           = hit;
        sts.victim_dirty  = sel_valid && sel_dirty;
    end

    always_comb
    begin
        result.cpu_ready           = cmd.ready;
        result.cpu_read_data       = cmd.serve_read ? FIELD_W'(sel_data) : '0;
        result.cpu_stall           = cmd.stall;
        result.memory_read_strobe  = cmd.rd_strobe;
        result.memory_write_strobe = cmd.wr_strobe;
        if (cmd.wr_strobe)
        begin
            result.memory_address = FIELD_W'(victim_addr);
        end
        else if (cmd.rd_strobe)
        begin
            result.memory_address = FIELD_W'(held_addr_reg);
        end
        else
        begin
            result.memory_address = '0;
        end
        result.memory_write_data = cmd.wr_strobe ? FIELD_W'(sel_data) : '0;
        result.line_valid_seen   = cmd.show_line && sel_valid;
        result.line_dirty_seen   = cmd.show_line && (sel_dirty || (hit && held_is_write_reg));
        result.controller_state  = cmd.state_code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_addr_reg     <= '0;
            held_wdata_reg    <= '0;
            held_is_write_reg <= 1'b0;
        end
        else if (cmd.latch_req)
        begin
            held_addr_reg     <= in_item.request_address[ADDRESS_BITS-1:0];
            held_wdata_reg    <= in_item.request_write_data[DATA_BITS-1:0];
            held_is_write_reg <= in_item.request_is_write;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_valid_reg <= '0;
            line_dirty_reg <= '0;
        end
        else
        begin
            if (cmd.fill_line)
            begin
                line_valid_reg[idx] <= 1'b1;
                line_dirty_reg[idx] <= 1'b0;
            end
            else if (cmd.clear_dirty)
            begin
                line_dirty_reg[idx] <= 1'b0;
            end
            else if (cmd.commit_write)
            begin
                line_dirty_reg[idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fill_line)
        begin
            line_tag_reg[idx]  <= held_tag;
            line_data_reg[idx] <= in_item.memory_read_data[DATA_BITS-1:0];
        end
        else if (cmd.commit_write)
        begin
            line_data_reg[idx] <= held_wdata_reg;
        end
    end

    `DMC_ASSERT_NEXT(a_fill_then_hit, cmd.fill_line, sts.hit, "filled line does not hit")

endmodule

@@ src/direct_mapped_cache_controller.sv @@
// The controller takes one beat per clock: every input beat is one tick of its
// four-state machine and yields exactly one result beat, which appears in the
// output register the cycle after the input beat is taken. Input is accepted
// whenever the output register is empty or is being drained in that cycle, so
// with the result side always ready the block runs at one beat per cycle; a
// miss spans several beats (compare, optional write back, allocate, compare
// again) and waits on memory_ready in write back and allocate. The line store
// holds sixteen one-word lines whose valid and dirty bits clear at reset; no
// clearing pass is needed.
// ---------------------------------------------------------------------------
// direct_mapped_cache_controller
// Direct-mapped write-back write-allocate cache controller with stream ports.
// ---------------------------------------------------------------------------
`include "direct_mapped_cache_controller_macros.svh"

module direct_mapped_cache_controller (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // request_valid, request_is_write, request_address[32], request_write_data[32],
    // memory_ready, memory_read_data[32], unused pad bits
    input  logic [dmc_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // cpu_ready, cpu_read_data[32], cpu_stall, memory_read_strobe,
    // memory_write_strobe, memory_address[32], memory_write_data[32],
    // line_valid_seen, line_dirty_seen, controller_state[2]
    output logic [dmc_pkg::M_TDATA_W-1:0]   m_tdata
);
    import dmc_pkg::*;

    logic                 step;
    in_item_t             in_item;
    out_item_t            result;
    dmc_cmd_t             cmd;
    dmc_status_t          sts;

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TDATA_W-1:0] m_data_next;

    assign s_tready = !m_valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb
    begin
        in_item.request_valid      = s_tdata[0];
        in_item.request_is_write   = s_tdata[1];
        in_item.request_address    = s_tdata[FIELD_W+1:2];
        in_item.request_write_data = s_tdata[2*FIELD_W+1:FIELD_W+2];
        in_item.memory_ready       = s_tdata[2*FIELD_W+2];
        in_item.memory_read_data   = s_tdata[3*FIELD_W+2:2*FIELD_W+3];
    end

    assign m_data_next = M_TDATA_W'({result.controller_state,
                                     result.line_dirty_seen,
                                     result.line_valid_seen,
                                     result.memory_write_data,
                                     result.memory_address,
                                     result.memory_write_strobe,
                                     result.memory_read_strobe,
                                     result.cpu_stall,
                                     result.cpu_read_data,
                                     result.cpu_ready});

    dmc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .sts   (sts),
        .cmd   (cmd)
    );

    dmc_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_item),
        .cmd     (cmd),
        .sts     (sts),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            m_data_reg <= m_data_next;
        end
    end

    `DMC_ASSERT_NEXT(a_beat_gives_result, step, m_valid_reg, "accepted beat left no result")

endmodule
